// ===== hdl/tcwt_pkg.sv =====
// Shared types and constants of the TCP connection window tracker.
package tcwt_pkg;

  // TCP flag bits of the header flags byte
  localparam logic [7:0] HDR_FIN = 8'h01;
  localparam logic [7:0] HDR_RST = 8'h04;
  localparam logic [7:0] HDR_PSH = 8'h08;
  localparam logic [7:0] HDR_ACK = 8'h10;

  // item kinds carried on in_tuser
  localparam logic [1:0] ACT_SEGMENT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_SEND    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OLD      = 3'd1;
  localparam logic [2:0] ST_WIN_FULL = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_PIPE     = 3'd4;
  localparam logic [2:0] ST_NOT_OPEN = 3'd5;

  // connection state as reported in the result
  localparam logic [1:0] CONN_CLOSED     = 2'd0;
  localparam logic [1:0] CONN_ESTAB      = 2'd1;
  localparam logic [1:0] CONN_CLOSE_WAIT = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ACK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_REM_WIN = 2'd3;

  localparam logic [15:0] RECV_WINDOW_RST = 16'd8192;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 96;

  typedef enum logic [2:0] {
    LINK_CLOSED     = 3'b001,
    LINK_ESTAB      = 3'b010,
    LINK_CLOSE_WAIT = 3'b100
  } link_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seg_seq;
    logic        flag_ack;
    logic        flag_psh;
    logic        flag_fin;
    logic        flag_rst;
    logic [15:0] seg_window;
    logic [15:0] length;
    logic        is_last;
  } item_t;

  typedef struct packed {
    link_state_t link;
    logic [31:0] send_seq;
    logic [31:0] ack_value;
    logic [15:0] in_use;
    logic [15:0] remote_window;
  } tcb_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  pkt_flags;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_ack;
    logic [15:0] pkt_window;
    logic [2:0]  status;
    logic [1:0]  conn_state;
    logic        window_grew;
  } result_t;

endpackage

// ===== hdl/tcwt_core.sv =====
// Combinational per-item update of the connection block and result build.
module tcwt_core
  import tcwt_pkg::*;
(
  input  item_t       item,
  input  tcb_t        tcb,
  input  logic [15:0] recv_window,
  output tcb_t        tcb_nxt,
  output result_t     res
);

  function automatic logic [15:0] free_win(input logic [15:0] rw, input logic [15:0] used);
    free_win = (used >= rw) ? 16'd0 : (rw - used);
  endfunction

  logic [31:0] seq_diff;
  logic [15:0] free_cur;
  logic        hdr;
  logic [7:0]  hflags;
  logic [31:0] hseq;

  assign seq_diff = item.seg_seq - tcb.ack_value;
  assign free_cur = free_win(recv_window, tcb.in_use);

  always_comb begin
    tcb_nxt         = tcb;
    res             = '0;
    res.status      = ST_OK;
    hdr             = 1'b0;
    hflags          = HDR_ACK;
    hseq            = tcb.send_seq;
    case (item.action)
      ACT_SEGMENT: begin
        if (tcb.link == LINK_CLOSED) begin
          res.status = ST_NOT_OPEN;
        end else if (tcb.link == LINK_ESTAB && !item.flag_ack) begin
          hdr    = 1'b1;
          hflags = HDR_RST;
        end else if (tcb.link == LINK_CLOSE_WAIT && item.flag_rst) begin
          tcb_nxt.link    = LINK_CLOSED;
          res.window_grew = 1'b1;
        end else if (seq_diff[31]) begin
          // serial-number compare: segment lies before the ack point
          hdr        = 1'b1;
          res.status = ST_OLD;
        end else if (free_cur < item.length) begin
          hdr        = 1'b1;
          res.status = ST_WIN_FULL;
        end else begin
          tcb_nxt.in_use    = tcb.in_use + item.length;
          tcb_nxt.ack_value = tcb.ack_value + 32'(item.length) + 32'(item.flag_fin);
          if (item.flag_fin) begin
            tcb_nxt.link = LINK_CLOSE_WAIT;
          end
          res.window_grew       = (item.seg_window > tcb.remote_window);
          tcb_nxt.remote_window = item.seg_window;
          hdr = item.flag_psh | item.flag_fin | (recv_window == 16'd0);
        end
      end
      ACT_READ: begin
        if (tcb.link != LINK_ESTAB) begin
          res.status = ST_NOT_OPEN;
        end else begin
          tcb_nxt.in_use = (item.length >= tcb.in_use) ? 16'd0 : (tcb.in_use - item.length);
          hdr = (tcb.in_use == recv_window);
        end
      end
      ACT_SEND: begin
        if (tcb.remote_window < item.length) begin
          res.status = (tcb.link == LINK_CLOSED) ? ST_PIPE : ST_BLOCKED;
        end else begin
          tcb_nxt.send_seq      = tcb.send_seq + 32'(item.length);
          tcb_nxt.remote_window = tcb.remote_window - item.length;
          hdr    = 1'b1;
          hflags = item.is_last ? (HDR_ACK | HDR_PSH) : HDR_ACK;
        end
      end
      default: begin
      end
    endcase

    // header carries the ack and free window as left by this item
    res.emit = hdr;
    if (hdr) begin
      res.pkt_flags  = hflags;
      res.pkt_seq    = hseq;
      res.pkt_ack    = tcb_nxt.ack_value;
      res.pkt_window = free_win(recv_window, tcb_nxt.in_use);
    end

    unique case (tcb_nxt.link)
      LINK_CLOSED:     res.conn_state = CONN_CLOSED;
      LINK_ESTAB:      res.conn_state = CONN_ESTAB;
      LINK_CLOSE_WAIT: res.conn_state = CONN_CLOSE_WAIT;
      default:         res.conn_state = CONN_CLOSED;
    endcase
  end

endmodule

// ===== hdl/tcp_connection_window_tracker.sv =====
// Top level of the TCP connection window tracker: stream ports, registers, checks.
// Keeps TCP state for one connection and answers each input transfer (arriving
// segment, application read or application send, chosen by in_tuser) with exactly
// one result transfer that carries any header to transmit and a status. An item
// is registered on acceptance and processed, once the output register is free,
// straight into the output register; one item is taken per cycle while the output
// is not stalled, a rate set by the single state update path (compares and 32-bit
// adds on the connection block). While a result waits, the input register takes
// one more item and then holds in_tready low until the result transfer frees the
// output. Configuration writes are registered and must be issued only while idle.
module tcp_connection_window_tracker
  import tcwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // slave side
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // seg_seq[31:0], flag_ack[32], flag_psh[33], flag_fin[34], flag_rst[35],
  // seg_window[51:36], length[67:52], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,  // action
  input  logic                   in_tlast,  // is_last
  // master side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pkt_flags[7:0], pkt_seq[39:8], pkt_ack[71:40], pkt_window[87:72],
  // status[90:88], conn_state[92:91], window_grew[93], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser, // emit
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  item_t       item_r;
  logic        item_valid_r;
  tcb_t        tcb_r;
  tcb_t        tcb_nxt;
  logic [15:0] recv_window_r;
  result_t     res_nxt;
  result_t     res_r;
  logic        out_valid_r;
  logic        fire;
  logic        in_xfer;
  logic        cfg_xfer;

  assign fire      = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || fire;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  tcwt_core u_core (
    .item        (item_r),
    .tcb         (tcb_r),
    .recv_window (recv_window_r),
    .tcb_nxt     (tcb_nxt),
    .res         (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
    if (in_xfer) begin
      item_r.action     <= in_tuser;
      item_r.seg_seq    <= in_tdata[31:0];
      item_r.flag_ack   <= in_tdata[32];
      item_r.flag_psh   <= in_tdata[33];
      item_r.flag_fin   <= in_tdata[34];
      item_r.flag_rst   <= in_tdata[35];
      item_r.seg_window <= in_tdata[51:36];
      item_r.length     <= in_tdata[67:52];
      item_r.is_last    <= in_tlast;
    end
  end

  // connection state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcb_r.link          <= LINK_ESTAB;
      tcb_r.send_seq      <= '0;
      tcb_r.ack_value     <= '0;
      tcb_r.in_use        <= '0;
      tcb_r.remote_window <= '0;
      recv_window_r       <= RECV_WINDOW_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_RECV_WINDOW:   recv_window_r       <= cfg_data[15:0];
        CFG_START_SEQ:     tcb_r.send_seq      <= cfg_data;
        CFG_START_ACK:     tcb_r.ack_value     <= cfg_data;
        CFG_START_REM_WIN: tcb_r.remote_window <= cfg_data[15:0];
        default: begin
        end
      endcase
    end else if (fire) begin
      tcb_r <= tcb_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.emit;
  assign out_tdata  = {2'b00, res_r.window_grew, res_r.conn_state, res_r.status,
                       res_r.pkt_window, res_r.pkt_ack, res_r.pkt_seq, res_r.pkt_flags};

  // a result without a header carries all-zero header fields
  a_no_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.emit |-> (res_r.pkt_flags == 8'd0 && res_r.pkt_seq == 32'd0 &&
                                    res_r.pkt_ack == 32'd0 && res_r.pkt_window == 16'd0))
    else $error("header fields nonzero without emit");

  // refused sends and items refused as not open never produce a header
  a_refused_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status == ST_BLOCKED || res_r.status == ST_PIPE ||
                    res_r.status == ST_NOT_OPEN) |-> !res_r.emit)
    else $error("header emitted with a refusal status");

  // a closed connection stays closed
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tcb_r.link == LINK_CLOSED |=> tcb_r.link == LINK_CLOSED)
    else $error("connection left the closed state");

endmodule
